FILE: rtl/lcdrf_pkg.sv
// ----------------------------------------------------------------------------
// lcdrf_pkg
// Shared types and constants for the rectangle fill command generator.
// ----------------------------------------------------------------------------
package lcdrf_pkg;

	// display controller command bytes
	localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	// panel dimensions are at most 4095, so clipped sizes fit in 12 bits
	localparam int DIM_W   = 12;
	localparam int COUNT_W = 18;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// one rectangle fill request
	typedef struct packed {
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
		logic [15:0]        fill_color;
	} rect_req_t;

	// one emitted controller item
	typedef struct packed {
		logic               is_data;
		logic [7:0]         out_byte;
		logic               is_pixel_run;
		logic [COUNT_W-1:0] pixel_count;
		logic [15:0]        pixel_color;
		logic               last;
	} fill_res_t;

	// classified and clipped job handed to the back end
	typedef struct packed {
		logic [15:0]        x0;
		logic [15:0]        x1;
		logic [15:0]        y0;
		logic [15:0]        y1;
		logic [COUNT_W-1:0] count;
		logic [15:0]        color;
	} fill_job_t;

endpackage

FILE: rtl/lcdrf_front.sv
// ----------------------------------------------------------------------------
// lcdrf_front
// Accepts requests, drops empty or off-screen ones, clips the rectangle and
// forms end coordinates and pixel count over two stages.
// ----------------------------------------------------------------------------
module lcdrf_front import lcdrf_pkg::*; #(
	parameter int PANEL_WIDTH  = 320,
	parameter int PANEL_HEIGHT = 480
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rect_req_t           request,
	input  logic                swap_dims,
	input  logic [QUEUE_AW:0]   queue_fill,
	output logic                push,
	output fill_job_t           push_job
);

	localparam logic signed [17:0] PW_E = 18'(PANEL_WIDTH);
	localparam logic signed [17:0] PH_E = 18'(PANEL_HEIGHT);
	localparam logic [QUEUE_AW+1:0] DEPTH_C = (QUEUE_AW+2)'(QUEUE_DEPTH);

	logic                    accept;
	logic signed [17:0]      x_e, y_e, w_e, h_e, aw_e, ah_e;
	logic signed [17:0]      cw_e, ch_e;
	logic                    drop;
	logic [QUEUE_AW+1:0]     credit_use;

	logic                    valid_s1;
	logic [15:0]             x0_s1, y0_s1, color_s1;
	logic [DIM_W-1:0]        cw_s1, ch_s1;
	logic [2*DIM_W-1:0]      prod;

	logic                    valid_s2;
	fill_job_t               job_s2;

	// queue slots already claimed by items in flight
	assign credit_use = {1'b0, queue_fill} + (QUEUE_AW+2)'(valid_s1)
		+ (QUEUE_AW+2)'(valid_s2);
	assign busy   = (credit_use >= DEPTH_C);
	assign accept = start && !busy;

	// classify and clip
	always_comb begin
		x_e  = {{2{request.rect_x[15]}}, request.rect_x};
		y_e  = {{2{request.rect_y[15]}}, request.rect_y};
		w_e  = {{2{request.rect_w[15]}}, request.rect_w};
		h_e  = {{2{request.rect_h[15]}}, request.rect_h};
		aw_e = swap_dims ? PH_E : PW_E;
		ah_e = swap_dims ? PW_E : PH_E;
		drop = (x_e < 0) || (y_e < 0) || (x_e >= aw_e) || (y_e >= ah_e)
			|| (w_e <= 0) || (h_e <= 0);
		cw_e = (x_e + w_e > aw_e) ? (aw_e - x_e) : w_e;
		ch_e = (y_e + h_e > ah_e) ? (ah_e - y_e) : h_e;
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !drop;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_s1    <= request.rect_x;
			y0_s1    <= request.rect_y;
			color_s1 <= request.fill_color;
			cw_s1    <= cw_e[DIM_W-1:0];
			ch_s1    <= ch_e[DIM_W-1:0];
		end
	end

	assign prod = cw_s1 * ch_s1;

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload: end coordinates and pixel count
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			job_s2.x0    <= x0_s1;
			job_s2.y0    <= y0_s1;
			job_s2.x1    <= x0_s1 + {{(16-DIM_W){1'b0}}, cw_s1} - 16'd1;
			job_s2.y1    <= y0_s1 + {{(16-DIM_W){1'b0}}, ch_s1} - 16'd1;
			job_s2.count <= prod[COUNT_W-1:0];
			job_s2.color <= color_s1;
		end
	end

	assign push     = valid_s2;
	assign push_job = job_s2;

endmodule

FILE: rtl/lcdrf_queue.sv
// ----------------------------------------------------------------------------
// lcdrf_queue
// Short job queue between the front end and the command sequencer.
// ----------------------------------------------------------------------------
module lcdrf_queue import lcdrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fill_job_t         push_job,
	input  logic              pop,
	output fill_job_t         head,
	output logic              empty,
	output logic [QUEUE_AW:0] fill
);

	localparam logic [QUEUE_AW:0] DEPTH_C = (QUEUE_AW+1)'(QUEUE_DEPTH);

	fill_job_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     fill_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (fill_q == '0);
	assign fill  = fill_q;

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q != DEPTH_C) || pop)
		else $error("job queue overflow");

	// no read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

endmodule

FILE: rtl/lcdrf_back.sv
// ----------------------------------------------------------------------------
// lcdrf_back
// Command sequencer: walks one job through its twelve controller items,
// one per cycle, and registers each onto the result port.
// ----------------------------------------------------------------------------
module lcdrf_back import lcdrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  fill_job_t  head,
	output logic       pop,
	output logic       result_valid,
	output fill_res_t  result
);

	localparam logic [3:0] STEP_CASET   = 4'd0;
	localparam logic [3:0] STEP_X0_HI   = 4'd1;
	localparam logic [3:0] STEP_X0_LO   = 4'd2;
	localparam logic [3:0] STEP_X1_HI   = 4'd3;
	localparam logic [3:0] STEP_X1_LO   = 4'd4;
	localparam logic [3:0] STEP_RASET   = 4'd5;
	localparam logic [3:0] STEP_Y0_HI   = 4'd6;
	localparam logic [3:0] STEP_Y0_LO   = 4'd7;
	localparam logic [3:0] STEP_Y1_HI   = 4'd8;
	localparam logic [3:0] STEP_Y1_LO   = 4'd9;
	localparam logic [3:0] STEP_RAMWR   = 4'd10;
	localparam logic [3:0] STEP_RUN     = 4'd11;

	fill_job_t   job_q;
	logic        job_valid_q;
	logic [3:0]  step_q;
	fill_res_t   item;
	logic        result_valid_q;
	fill_res_t   result_q;

	// take the next job as the current one finishes
	assign pop = !empty && (!job_valid_q || (step_q == STEP_RUN));

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= STEP_CASET;
		end else if (pop) begin
			job_valid_q <= 1'b1;
			step_q      <= STEP_CASET;
		end else if (job_valid_q) begin
			if (step_q == STEP_RUN) begin
				job_valid_q <= 1'b0;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// current job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	// item for the current step
	always_comb begin
		item         = '0;
		item.is_data = 1'b1;
		case (step_q)
			STEP_CASET: begin
				item.is_data  = 1'b0;
				item.out_byte = CMD_COLUMN_SET;
			end
			STEP_X0_HI: item.out_byte = job_q.x0[15:8];
			STEP_X0_LO: item.out_byte = job_q.x0[7:0];
			STEP_X1_HI: item.out_byte = job_q.x1[15:8];
			STEP_X1_LO: item.out_byte = job_q.x1[7:0];
			STEP_RASET: begin
				item.is_data  = 1'b0;
				item.out_byte = CMD_ROW_SET;
			end
			STEP_Y0_HI: item.out_byte = job_q.y0[15:8];
			STEP_Y0_LO: item.out_byte = job_q.y0[7:0];
			STEP_Y1_HI: item.out_byte = job_q.y1[15:8];
			STEP_Y1_LO: item.out_byte = job_q.y1[7:0];
			STEP_RAMWR: begin
				item.is_data  = 1'b0;
				item.out_byte = CMD_MEMORY_WRITE;
			end
			STEP_RUN: begin
				item.is_pixel_run = 1'b1;
				item.pixel_count  = job_q.count;
				item.pixel_color  = job_q.color;
				item.last         = 1'b1;
			end
			default: item = '0;
		endcase
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= job_valid_q;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		result_q <= item;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// step never runs past the pixel run
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (step_q <= STEP_RUN))
		else $error("sequencer step out of range");

	// a finished transaction is followed by silence or a fresh column-set
	a_next_job: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.last) |=>
			(!result_valid_q || (!result_q.is_data && result_q.out_byte == CMD_COLUMN_SET)))
		else $error("job sequence broken after pixel run");

endmodule

FILE: rtl/lcd_rect_fill_command_generator.sv
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_generator
// Turns rectangle fill requests into display controller command, parameter
// and pixel-run items.
// ----------------------------------------------------------------------------
// path: with the sequencer idle, an accepted request passes the front stage 1 and stage 2
//   registers, the job queue, the sequencer state and the result strobe; the other eleven follow
// throughput: the sequencer emits one item per cycle, twelve per drawn request; a rejected
//   request is accepted but emits nothing
// reset: rotation returns to 0, job queue and sequencer empty
// results leave on a strobe and cannot be held off by the receiver
module lcd_rect_fill_command_generator import lcdrf_pkg::*; #(
	parameter int PANEL_WIDTH  = 320,
	parameter int PANEL_HEIGHT = 480
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  rect_req_t  request,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output logic       result_valid,
	output fill_res_t  result
);

	logic [1:0]          rotation_q;
	logic                push, pop, empty;
	fill_job_t           push_job, head;
	logic [QUEUE_AW:0]   queue_fill;

	// rotation register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			rotation_q <= cfg_data;
		end
	end

	// request classification and clipping
	lcdrf_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.swap_dims  (rotation_q[0]),
		.queue_fill (queue_fill),
		.push       (push),
		.push_job   (push_job)
	);

	// job queue
	lcdrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.fill     (queue_fill)
	);

	// command sequencer
	lcdrf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: test/tb_lcd_rect_fill_command_generator.sv
// ----------------------------------------------------------------------------
// tb_lcd_rect_fill_command_generator
// Self-checking bench for the rectangle fill command generator. A directed
// table covers the screen corners, clipping, rejected origins and empty sizes;
// rows use each rotation. Random requests follow, mostly on-screen rectangles
// with random sizes, plus broken and raw noise requests. Every emitted
// controller item is compared against a local model of the command sequence.
// ----------------------------------------------------------------------------
module tb_lcd_rect_fill_command_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdrf_pkg::*;

	localparam int PANEL_W      = 320;
	localparam int PANEL_H      = 480;
	localparam int SETTLE_CYC   = 20;
	localparam int STALL_LIMIT  = 500;
	localparam int PHASE_DRAWN  = 13;
	localparam int N_PHASES     = 4;
	localparam int ITEMS_PER_RQ = 12;

	// one row of the directed table
	typedef struct {
		int        rot;
		rect_req_t req;
		bit        typed;
		bit        drawn;
		int        x0;
		int        x1;
		int        y0;
		int        y1;
		int        count;
	} fill_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rect_req_t request;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_data;
	logic      result_valid;
	fill_res_t result;

	fill_res_t controller_items_due[$];
	fill_row_t fill_table[$];
	int        mismatch_count;
	int        cur_rotation;
	int        stall_cycles;
	bit        no_idle;

	lcd_rect_fill_command_generator #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic fill_res_t make_item(logic dc, logic [7:0] b, logic run,
			logic [COUNT_W-1:0] cnt, logic [15:0] color, logic lst);
		fill_res_t it;
		it.is_data      = dc;
		it.out_byte     = b;
		it.is_pixel_run = run;
		it.pixel_count  = cnt;
		it.pixel_color  = color;
		it.last         = lst;
		return it;
	endfunction

	// queue the twelve items that draw one window
	function automatic void push_window(logic [15:0] x0, logic [15:0] x1, logic [15:0] y0,
			logic [15:0] y1, logic [COUNT_W-1:0] cnt, logic [15:0] color);
		controller_items_due.push_back(make_item(1'b0, CMD_COLUMN_SET, 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, x0[15:8], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, x0[7:0], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, x1[15:8], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, x1[7:0], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b0, CMD_ROW_SET, 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, y0[15:8], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, y0[7:0], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, y1[15:8], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b1, y1[7:0], 1'b0, '0, '0, 1'b0));
		controller_items_due.push_back(make_item(1'b0, CMD_MEMORY_WRITE, 1'b0, '0, '0,
			1'b0));
		controller_items_due.push_back(make_item(1'b1, 8'h00, 1'b1, cnt, color, 1'b1));
	endfunction

	// classify and clip one request against the active area; returns 1 if drawn
	function automatic bit predict_fill_sequence(rect_req_t r);
		int x, y, w, h, aw, ah;
		x  = r.rect_x;
		y  = r.rect_y;
		w  = r.rect_w;
		h  = r.rect_h;
		aw = cur_rotation[0] ? PANEL_H : PANEL_W;
		ah = cur_rotation[0] ? PANEL_W : PANEL_H;
		if (x < 0 || y < 0 || x >= aw || y >= ah) return 1'b0;
		if (w <= 0 || h <= 0) return 1'b0;
		if (x + w > aw) w = aw - x;
		if (y + h > ah) h = ah - y;
		push_window(16'(x), 16'(x + w - 1), 16'(y), 16'(y + h - 1), COUNT_W'(w * h),
			r.fill_color);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// check every emitted item against the oldest expectation
	always @(posedge clk) begin
		fill_res_t want;
		if (arst_n && result_valid) begin
			if (controller_items_due.size() == 0) begin
				report_mismatch("unexpected item", 32'(result), 32'h0);
			end else begin
				want = controller_items_due.pop_front();
				if (result.is_data !== want.is_data)
					report_mismatch("is_data", 32'(result.is_data), 32'(want.is_data));
				if (result.out_byte !== want.out_byte)
					report_mismatch("out_byte", 32'(result.out_byte), 32'(want.out_byte));
				if (result.is_pixel_run !== want.is_pixel_run)
					report_mismatch("is_pixel_run", 32'(result.is_pixel_run),
						32'(want.is_pixel_run));
				if (result.pixel_count !== want.pixel_count)
					report_mismatch("pixel_count", 32'(result.pixel_count),
						32'(want.pixel_count));
				if (result.pixel_color !== want.pixel_color)
					report_mismatch("pixel_color", 32'(result.pixel_color),
						32'(want.pixel_color));
				if (result.last !== want.last)
					report_mismatch("last", 32'(result.last), 32'(want.last));
			end
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// present one request and return at the edge that accepts it
	task automatic drive_rect(rect_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// write rotation once everything in flight has drained
	task automatic write_rotation(int rot);
		start <= 1'b0;
		while (controller_items_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= 2'(rot);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		cur_rotation = rot;
	endtask

	task automatic add_row(int rot, int x, int y, int w, int h, int color, bit typed,
			bit drawn, int x0 = 0, int x1 = 0, int y0 = 0, int y1 = 0, int count = 0);
		fill_row_t row;
		row.rot             = rot;
		row.req.rect_x      = 16'(x);
		row.req.rect_y      = 16'(y);
		row.req.rect_w      = 16'(w);
		row.req.rect_h      = 16'(h);
		row.req.fill_color  = 16'(color);
		row.typed           = typed;
		row.drawn           = drawn;
		row.x0              = x0;
		row.x1              = x1;
		row.y0              = y0;
		row.y1              = y1;
		row.count           = count;
		fill_table.push_back(row);
	endtask

	// random request: mostly on-screen rectangles, some broken, some raw noise
	function automatic rect_req_t random_rect();
		rect_req_t r;
		int aw, ah, x, y, w, h, sel;
		aw  = cur_rotation[0] ? PANEL_H : PANEL_W;
		ah  = cur_rotation[0] ? PANEL_W : PANEL_H;
		sel = $urandom_range(0, 9);
		x   = $urandom_range(0, aw - 1);
		y   = $urandom_range(0, ah - 1);
		case ($urandom_range(0, 3))
			0: w = $urandom_range(1, 8);
			1: w = $urandom_range(1, aw);
			2: w = $urandom_range(1, 32767);
			default: w = aw - x;
		endcase
		case ($urandom_range(0, 3))
			0: h = $urandom_range(1, 8);
			1: h = $urandom_range(1, ah);
			2: h = $urandom_range(1, 32767);
			default: h = ah - y;
		endcase
		if (sel == 7) begin
			// empty size on a valid origin
			if ($urandom_range(0, 1)) w = -$urandom_range(0, 32768);
			else h = -$urandom_range(0, 32768);
		end else if (sel == 8) begin
			// origin off screen on either side
			case ($urandom_range(0, 3))
				0: x = -$urandom_range(1, 32768);
				1: y = -$urandom_range(1, 32768);
				2: x = $urandom_range(aw, 32767);
				default: y = $urandom_range(ah, 32767);
			endcase
		end
		r.rect_x     = 16'(x);
		r.rect_y     = 16'(y);
		r.rect_w     = 16'(w);
		r.rect_h     = 16'(h);
		r.fill_color = 16'($urandom);
		if (sel == 9) r = rect_req_t'({$urandom, $urandom, 16'($urandom)});
		return r;
	endfunction

	// stimulus
	initial begin
		int n_drawn;
		int rot;
		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		mismatch_count = 0;
		cur_rotation   = 0;
		stall_cycles   = 0;
		no_idle        = 1'b0;

		// full screen, corners and clipping, rotation 0
		add_row(0, 0, 0, 320, 480, 'hFFFF, 1, 1, 0, 319, 0, 479, 153600);
		add_row(0, 0, 0, 1, 1, 'h0000, 1, 1, 0, 0, 0, 0, 1);
		add_row(0, 319, 479, 1, 1, 'hA5A5, 1, 1, 319, 319, 479, 479, 1);
		add_row(0, 319, 479, 32767, 32767, 'h5A5A, 1, 1, 319, 319, 479, 479, 1);
		add_row(0, 0, 0, 32767, 32767, 'h1234, 1, 1, 0, 319, 0, 479, 153600);
		// origin negative or off screen
		add_row(0, -1, 0, 10, 10, 'hFFFF, 1, 0);
		add_row(0, 0, -1, 10, 10, 'hFFFF, 1, 0);
		add_row(0, 320, 0, 10, 10, 'hFFFF, 1, 0);
		add_row(0, 0, 480, 10, 10, 'hFFFF, 1, 0);
		add_row(0, -32768, -32768, 32767, 32767, 'hFFFF, 1, 0);
		add_row(0, 32767, 32767, 32767, 32767, 'hFFFF, 1, 0);
		// empty sizes, then two rectangles predicted by the model
		add_row(0, 10, 10, 0, 5, 'hFFFF, 1, 0);
		add_row(0, 10, 10, 5, 0, 'hFFFF, 1, 0);
		add_row(0, 10, 10, -1, 5, 'hFFFF, 1, 0);
		add_row(0, 10, 10, 5, -32768, 'hFFFF, 1, 0);
		add_row(0, 100, 200, 50, 60, 'hF800, 0, 0);
		add_row(0, 300, 470, 40, 40, 'h001F, 0, 0);
		// swapped dimensions under rotations 1 and 3, unswapped under rotation 2
		add_row(1, 0, 0, 480, 320, 'h07E0, 1, 1, 0, 479, 0, 319, 153600);
		add_row(1, 479, 319, 1, 1, 'hFFFF, 1, 1, 479, 479, 319, 319, 1);
		add_row(1, 320, 100, 10, 10, 'h8001, 0, 0);
		add_row(1, 0, 320, 10, 10, 'hFFFF, 1, 0);
		add_row(2, 319, 0, 2, 480, 'h0F0F, 1, 1, 319, 319, 0, 479, 480);
		add_row(3, 480, 0, 10, 10, 'hFFFF, 1, 0);
		add_row(3, 400, 300, 200, 100, 'hF0F0, 0, 0);
		add_row(3, 256, 256, 'h7FFF, 1, 'hAAAA, 0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (fill_table[i]) begin
			if (fill_table[i].rot != cur_rotation) write_rotation(fill_table[i].rot);
			drive_rect(fill_table[i].req);
			if (!fill_table[i].typed)
				void'(predict_fill_sequence(fill_table[i].req));
			else if (fill_table[i].drawn)
				push_window(16'(fill_table[i].x0), 16'(fill_table[i].x1),
					16'(fill_table[i].y0), 16'(fill_table[i].y1),
					COUNT_W'(fill_table[i].count), fill_table[i].req.fill_color);
		end

		// random phases, extremes of rotation first
		for (int p = 0; p < N_PHASES; p++) begin
			rot = (p == 0) ? 3 : (p == 1) ? 0 : $urandom_range(0, 3);
			write_rotation(rot);
			n_drawn = 0;
			for (int k = 0; n_drawn < PHASE_DRAWN; k++) begin
				rect_req_t r;
				if (k % 8 == 0) no_idle = ($urandom_range(0, 2) == 0);
				r = random_rect();
				drive_rect(r);
				if (predict_fill_sequence(r)) n_drawn++;
			end
		end

		// drain
		start <= 1'b0;
		while (controller_items_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lcdrf_pkg.sv
rtl/lcdrf_front.sv
rtl/lcdrf_queue.sv
rtl/lcdrf_back.sv
rtl/lcd_rect_fill_command_generator.sv
test/tb_lcd_rect_fill_command_generator.sv
